// ----- rtl/core/tcarf_pkg.sv -----
package tcarf_pkg;

    localparam int DATA_W  = 16;
    localparam int REG_CNT = 8;
    localparam int ADDR_W  = $clog2(REG_CNT);
    localparam int IMM_W   = 8;
    localparam int SHAMT_W = $clog2(DATA_W);

    // Instruction field positions
    localparam int RX_LSB  = 13;
    localparam int RY_LSB  = 10;
    localparam int IMM_LSB = 5;
    localparam int OP_LSB  = 2;
    localparam int FMT_BIT = 0;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_AND = 3'd2,
        OP_OR  = 3'd3,
        OP_XOR = 3'd4,
        OP_SHL = 3'd5,
        OP_SHR = 3'd6,
        OP_CMP = 3'd7
    } alu_op_t;

    localparam data_t CMP_EQ = data_t'(0);
    localparam data_t CMP_GT = data_t'(1);
    localparam data_t CMP_LT = data_t'(2);

    typedef struct packed {
        logic  en;
        addr_t addr;
        data_t data;
    } wr_port_t;

endpackage

// ----- rtl/core/tcarf_regfile.sv -----
module tcarf_regfile
    import tcarf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     rd_en,
    input  addr_t    rd_addr_a,
    input  addr_t    rd_addr_b,
    output data_t    rd_data_a,
    output data_t    rd_data_b,
    input  wr_port_t wr
);

    data_t              mem [REG_CNT];
    logic [REG_CNT-1:0] valid_reg;
    data_t              mem_a_reg;
    data_t              mem_b_reg;
    data_t              byp_reg;
    logic               byp_a_reg;
    logic               byp_b_reg;
    logic               vld_a_reg;
    logic               vld_b_reg;

    // Bypass a write landing on the same edge; unwritten entries read as zero.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            mem_a_reg <= mem[rd_addr_a];
            mem_b_reg <= mem[rd_addr_b];
            byp_reg   <= wr.data;
            byp_a_reg <= wr.en && wr.addr == rd_addr_a;
            byp_b_reg <= wr.en && wr.addr == rd_addr_b;
            vld_a_reg <= valid_reg[rd_addr_a];
            vld_b_reg <= valid_reg[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data_a = byp_a_reg ? byp_reg : (vld_a_reg ? mem_a_reg : '0);
    assign rd_data_b = byp_b_reg ? byp_reg : (vld_b_reg ? mem_b_reg : '0);

endmodule

// ----- rtl/core/tcarf_alu.sv -----
module tcarf_alu
    import tcarf_pkg::*;
(
    input  alu_op_t op,
    input  data_t   a,
    input  data_t   b,
    output data_t   y
);

    logic big_shift;

    assign big_shift = |b[DATA_W-1:SHAMT_W];

    always_comb begin
        case (op)
            OP_ADD: y = a + b;
            OP_SUB: y = a - b;
            OP_AND: y = a & b;
            OP_OR:  y = a | b;
            OP_XOR: y = a ^ b;
            OP_SHL: y = big_shift ? '0 : a << b[SHAMT_W-1:0];
            OP_SHR: y = big_shift ? '0 : a >> b[SHAMT_W-1:0];
            OP_CMP: begin
                if (a == b) begin
                    y = CMP_EQ;
                end else if (a > b) begin
                    y = CMP_GT;
                end else begin
                    y = CMP_LT;
                end
            end
            default: y = '0;
        endcase
    end

endmodule

// ----- rtl/core/tiny_cpu_alu_register_file.sv -----
// Eight-register, 16-bit ALU datapath with register write-back.
//
// Input channel (s_valid/s_ready/s_instruction) takes one instruction word
// per transfer. Result channel (m_valid/m_ready) returns the value written
// back (m_result_value) and the register it went to (m_dest_register),
// exactly one result per instruction, in order.
//
// The register file read is synchronous; the ALU then computes the result,
// and the write-back goes into the output register. Throughput: one
// instruction per cycle while the output is not stalled; a write-back is
// bypassed into the read of the following instruction, so dependent
// instructions issue back to back.
//
// Reset clears all registers to zero (per-entry valid bits) and empties the
// pipeline. When the receiver stalls, the output register holds its result,
// the instruction behind it waits in the execute stage, and s_ready drops
// only when both are full.
module tiny_cpu_alu_register_file
    import tcarf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_instruction,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_result_value,
    output logic [ADDR_W-1:0] m_dest_register
);

    logic       s_xfer;
    logic       ex_adv;
    logic       ex_valid_reg;
    logic       ex_valid_next;
    addr_t      ex_rx_reg;
    alu_op_t    ex_op_reg;
    logic       ex_fmt_reg;
    logic [IMM_W-1:0] ex_imm_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    data_t      m_result_reg;
    addr_t      m_dest_reg;
    data_t      opnd_a;
    data_t      opnd_b;
    data_t      rd_b;
    data_t      alu_y;
    wr_port_t   wr;

    assign ex_adv = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !ex_valid_reg || ex_adv;
    assign s_xfer = s_valid && s_ready;

    assign wr.en   = ex_adv;
    assign wr.addr = ex_rx_reg;
    assign wr.data = alu_y;

    tcarf_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_xfer),
        .rd_addr_a (s_instruction[RX_LSB +: ADDR_W]),
        .rd_addr_b (s_instruction[RY_LSB +: ADDR_W]),
        .rd_data_a (opnd_a),
        .rd_data_b (rd_b),
        .wr        (wr)
    );

    assign opnd_b = ex_fmt_reg ? DATA_W'(ex_imm_reg) : rd_b;

    tcarf_alu u_alu (
        .op (ex_op_reg),
        .a  (opnd_a),
        .b  (opnd_b),
        .y  (alu_y)
    );

    always_comb begin
        ex_valid_next = ex_valid_reg;
        if (s_xfer) begin
            ex_valid_next = 1'b1;
        end else if (ex_adv) begin
            ex_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (ex_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            ex_valid_reg <= ex_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ex_rx_reg  <= s_instruction[RX_LSB +: ADDR_W];
            ex_op_reg  <= alu_op_t'(s_instruction[OP_LSB +: 3]);
            ex_fmt_reg <= s_instruction[FMT_BIT];
            ex_imm_reg <= s_instruction[IMM_LSB +: IMM_W];
        end
        if (ex_adv) begin
            m_result_reg <= alu_y;
            m_dest_reg   <= ex_rx_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_value  = m_result_reg;
    assign m_dest_register = m_dest_reg;

endmodule

// ----- rtl/core/tcarf_checker.sv -----
module tcarf_checker
    import tcarf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_result_value,
    input logic [ADDR_W-1:0] m_dest_register
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
                                && $stable(m_dest_register))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A result appearing from empty comes from an input transfer that passed through the execute stage.
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transfer");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind tiny_cpu_alu_register_file tcarf_checker u_tcarf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_value  (m_result_value),
    .m_dest_register (m_dest_register)
);

// ----- verif/tb_tiny_cpu_alu_register_file.sv -----
module tb_tiny_cpu_alu_register_file;
    import tcarf_pkg::*;

    localparam bit FMT_REG = 1'b0;
    localparam bit FMT_IMM = 1'b1;
    localparam int RANDOM_WORDS = 1400;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        logic [15:0] word;
        bit          known;
        data_t       value;
    } dir_row_t;

    typedef struct {
        data_t value;
        addr_t dest;
    } writeback_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instruction;
    logic        m_valid;
    logic        m_ready;
    data_t       m_result_value;
    addr_t       m_dest_register;

    data_t      reg_model [REG_CNT];
    writeback_t pending_writebacks[$];
    dir_row_t   dir_rows[$];
    int         errors = 0;
    bit         send_busy = 0;
    bit         recv_busy = 0;

    tiny_cpu_alu_register_file DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instruction   (s_instruction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_dest_register (m_dest_register)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [15:0] enc(addr_t rx, logic [IMM_W-1:0] imm, alu_op_t op, bit fmt);
        return {rx, imm, op, 1'b0, fmt};
    endfunction

    // Execute one instruction on the register model and write the result back.
    function automatic void alu_writeback(input logic [15:0] word,
                                          output data_t value, output addr_t dest);
        addr_t            rx;
        addr_t            ry;
        logic [IMM_W-1:0] imm;
        alu_op_t          op;
        data_t            a;
        data_t            b;
        rx  = word[RX_LSB +: ADDR_W];
        ry  = word[RY_LSB +: ADDR_W];
        imm = word[IMM_LSB +: IMM_W];
        op  = alu_op_t'(word[OP_LSB +: 3]);
        a   = reg_model[rx];
        b   = word[FMT_BIT] ? data_t'(imm) : reg_model[ry];
        case (op)
            OP_ADD: value = a + b;
            OP_SUB: value = a - b;
            OP_AND: value = a & b;
            OP_OR:  value = a | b;
            OP_XOR: value = a ^ b;
            OP_SHL: value = (b > DATA_W - 1) ? '0 : data_t'(a << b);
            OP_SHR: value = (b > DATA_W - 1) ? '0 : data_t'(a >> b);
            default: value = (a == b) ? CMP_EQ : ((a > b) ? CMP_GT : CMP_LT);
        endcase
        reg_model[rx] = value;
        dest = rx;
    endfunction

    // Bias shift amounts toward the useful range so shifts do not mostly give zero.
    function automatic logic [15:0] random_word();
        alu_op_t          op;
        logic [IMM_W-1:0] imm;
        bit               fmt;
        logic [15:0]      word;
        if ($urandom_range(0, 7) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        op  = alu_op_t'($urandom_range(0, 7));
        fmt = 1'($urandom_range(0, 1));
        imm = 8'($urandom_range(0, 255));
        if (fmt && (op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) != 0) begin
            imm = 8'($urandom_range(0, 17));
        end
        word = enc(addr_t'($urandom_range(0, 7)), imm, op, fmt);
        word[1] = 1'($urandom_range(0, 1));
        return word;
    endfunction

    function automatic int draw_wait(bit busy);
        return busy ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic issue(input logic [15:0] word, input bit known, input data_t value);
        int         gap;
        writeback_t wb;
        if ($urandom_range(0, 39) == 0) send_busy = ~send_busy;
        gap = draw_wait(send_busy);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_instruction <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        alu_writeback(word, wb.value, wb.dest);
        if (known) wb.value = value;
        pending_writebacks.push_back(wb);
    endtask

    // Sender: directed rows, random words, then drain.
    initial begin
        s_valid       = 1'b0;
        s_instruction = '0;
        foreach (reg_model[i]) reg_model[i] = '0;
        dir_rows = '{
            '{16'h0000,                                  1'b1, 16'h0000},
            '{enc(1, 8'hFF, OP_ADD, FMT_IMM),            1'b1, 16'h00FF},
            '{enc(2, 8'h01, OP_SUB, FMT_IMM),            1'b1, 16'hFFFF},
            '{enc(2, 8'h01, OP_ADD, FMT_IMM),            1'b1, 16'h0000},
            '{enc(3, 8'h80, OP_ADD, FMT_IMM),            1'b1, 16'h0080},
            '{enc(3, 8'h08, OP_SHL, FMT_IMM),            1'b1, 16'h8000},
            '{enc(3, 8'h01, OP_SHL, FMT_IMM),            1'b1, 16'h0000},
            '{enc(4, 8'hFF, OP_ADD, FMT_IMM),            1'b1, 16'h00FF},
            '{enc(4, 8'h10, OP_SHL, FMT_IMM),            1'b1, 16'h0000},
            '{enc(5, 8'h01, OP_SUB, FMT_IMM),            1'b1, 16'hFFFF},
            '{enc(5, 8'h0F, OP_SHR, FMT_IMM),            1'b1, 16'h0001},
            '{enc(6, 8'h01, OP_SUB, FMT_IMM),            1'b1, 16'hFFFF},
            '{enc(6, 8'hFF, OP_SHR, FMT_IMM),            1'b1, 16'h0000},
            '{enc(7, 8'h00, OP_CMP, FMT_IMM),            1'b1, CMP_EQ},
            '{enc(7, 8'h01, OP_CMP, FMT_IMM),            1'b1, CMP_LT},
            '{enc(7, 8'h01, OP_CMP, FMT_IMM),            1'b1, CMP_GT},
            '{enc(1, {3'd5, 5'h00}, OP_AND, FMT_REG),    1'b0, '0},
            '{enc(1, {3'd7, 5'h00}, OP_OR, FMT_REG),     1'b0, '0},
            '{enc(1, {3'd1, 5'h00}, OP_XOR, FMT_REG),    1'b1, 16'h0000},
            '{enc(5, {3'd5, 5'h00}, OP_SUB, FMT_REG),    1'b1, 16'h0000},
            '{enc(1, 8'h05, OP_ADD, FMT_IMM) | 16'h0002, 1'b0, '0},
            '{enc(2, {3'd1, 5'h1F}, OP_ADD, FMT_REG),    1'b0, '0},
            '{enc(2, 8'hA3, OP_OR, FMT_IMM),             1'b0, '0},
            '{enc(4, 8'h0F, OP_ADD, FMT_IMM),            1'b0, '0},
            '{enc(1, {3'd4, 5'h00}, OP_SHL, FMT_REG),    1'b0, '0},
            '{16'hFFFF,                                  1'b0, '0}
        };
        wait (aresetn === 1'b1);
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            issue(dir_rows[i].word, dir_rows[i].known, dir_rows[i].value);
        end
        repeat (RANDOM_WORDS) issue(random_word(), 1'b0, '0);
        s_valid <= 1'b0;
        while (pending_writebacks.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
    initial begin
        int stall;
        int transfers;
        m_ready   = 1'b0;
        transfers = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_busy = ~recv_busy;
            stall = (transfers == HOLD_AT) ? HOLD_CYCLES : draw_wait(recv_busy);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            transfers++;
        end
    end

    always @(posedge aclk) begin
        writeback_t wb;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writebacks.size() == 0) begin
                $error("unexpected transfer: m_result_value=%h m_dest_register=%0d",
                       m_result_value, m_dest_register);
                errors++;
            end else begin
                wb = pending_writebacks.pop_front();
                if (m_result_value !== wb.value) begin
                    $error("m_result_value: expected %h, got %h", wb.value, m_result_value);
                    errors++;
                end
                if (m_dest_register !== wb.dest) begin
                    $error("m_dest_register: expected %0d, got %0d", wb.dest, m_dest_register);
                    errors++;
                end
            end
        end
    end

endmodule
